>>> rtl/ballistic_drag_euler_step_defines.svh
// Assertion helpers
`ifndef BALLISTIC_DRAG_EULER_STEP_DEFINES_SVH
`define BALLISTIC_DRAG_EULER_STEP_DEFINES_SVH
`define BDE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication failed");
`define BDE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`endif

>>> rtl/bde_pkg.sv
package bde_pkg;
  localparam int unsigned PosWidthDef = 48;
  localparam int unsigned VelWidth    = 28;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDatWidth = 48;
  localparam logic [CfgIdxWidth-1:0] CfgTimeStep = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgDrag     = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgGravity  = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CfgFloor    = 2'd3;
  localparam logic [23:0] TimeStepRst = 24'd1678;
  localparam logic [31:0] DragRst     = 32'd203885;
  localparam logic [23:0] GravityRst  = 24'd642689;
  localparam logic signed [47:0] FloorRst = -48'sd478412800;
endpackage

>>> rtl/bde_isqrt.sv
module bde_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [55:0] rad_i,
  output logic        done_o,
  output logic [27:0] root_o
);
  logic [55:0] rad_q, rad_d;
  logic [29:0] rem_q, rem_d;
  logic [27:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [31:0] shifted;
  logic [31:0] trial;

  always_comb begin
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, rad_q[55:54]};
    trial   = {2'b00, root_q, 2'b01};
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = 5'd27;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // bit-pair restoring square root, one result bit per cycle
      rad_d = {rad_q[53:0], 2'b00};
      if (shifted >= trial) begin
        rem_d  = 30'(shifted - trial);
        root_d = {root_q[26:0], 1'b1};
      end else begin
        rem_d  = shifted[29:0];
        root_d = {root_q[26:0], 1'b0};
      end
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

>>> rtl/ballistic_drag_euler_step.sv
// A launch beat goes straight to the output; an advance step runs to m_axis_tvalid
// through two square roots on one shared root unit plus one shared multiplier.
// The next input beat is taken only after the result beat has been accepted;
// s_axis_tready is low while a step runs and while a result waits.
// Reset (rst_ni low, async) clears state and loads register defaults.
module ballistic_drag_euler_step #(
  parameter int unsigned POSITION_WIDTH = bde_pkg::PosWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // launch_vx, launch_vy
  input  logic s_axis_tuser,         // mode
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // pos_x, pos_y, vel_x, vel_y, path_length, below_floor, zero fill
  output logic [((3*POSITION_WIDTH+56)+7)/8*8-1:0] m_axis_tdata,
  input  logic cfg_we_i,
  input  logic [bde_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [bde_pkg::CfgDatWidth-1:0] cfg_data_i
);
  import bde_pkg::*;
  localparam int unsigned P  = POSITION_WIDTH;
  localparam int unsigned OW = ((3*P+56)+7)/8*8;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ0, S_SQ1, S_RT0, S_KS, S_TX, S_TY, S_VX, S_VY,
    S_PX, S_PY, S_SQ2, S_SQ3, S_RT1, S_DL, S_OUT
  } state_e;

  logic [23:0] dt_q;
  logic [31:0] drag_q;
  logic [23:0] grav_q;
  logic signed [P-1:0] floor_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= TimeStepRst; drag_q <= DragRst; grav_q <= GravityRst;
      floor_q <= P'(FloorRst);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTimeStep: dt_q <= cfg_data_i[23:0];
        CfgDrag:     drag_q <= cfg_data_i[31:0];
        CfgGravity:  grav_q <= cfg_data_i[23:0];
        CfgFloor:    floor_q <= P'($signed(cfg_data_i));
        default: ;
      endcase
    end
  end

  state_e st_q;
  logic signed [P-1:0] px_q, py_q;
  logic signed [27:0] vx_q, vy_q;
  logic [P-2:0] len_q;
  logic fin_q, ovalid_q;
  logic signed [63:0] acc_q;   // shared product/sum register
  logic signed [63:0] tmp_q;
  logic signed [35:0] ks_q;

  // shared multiplier
  logic signed [40:0] ma;
  logic signed [28:0] mb;
  logic signed [69:0] prod;
  assign prod = ma * mb;

  logic rt_start, rt_done;
  logic [27:0] rt_root;
  logic [55:0] rt_rad;
  bde_isqrt u_rt (.clk_i, .rst_ni, .start_i(rt_start), .rad_i(rt_rad),
                  .done_o(rt_done), .root_o(rt_root));

  function automatic logic signed [27:0] sat28(input logic signed [63:0] v);
    if (v > 64'sd134217727) return 28'sh7ffffff;
    if (v < -64'sd134217728) return 28'sh8000000;
    return v[27:0];
  endfunction
  function automatic logic signed [P-1:0] satp(input logic signed [P-1:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [64:0] mx;
    s  = 65'(a) + 65'(b);
    mx = (65'sd1 <<< (P-1)) - 65'sd1;
    if (s > mx) return mx[P-1:0];
    if (s < -mx - 65'sd1) return P'(-mx - 65'sd1);
    return s[P-1:0];
  endfunction

  always_comb begin
    ma = '0; mb = '0;
    case (st_q)
      S_SQ0, S_SQ2: begin ma = 41'(vx_q); mb = 29'(vx_q); end
      S_SQ1, S_SQ3: begin ma = 41'(vy_q); mb = 29'(vy_q); end
      S_KS:  begin ma = $signed({9'd0, drag_q}); mb = $signed({1'b0, rt_root}); end
      S_TX:  begin ma = 41'(ks_q); mb = 29'(vx_q); end
      S_TY:  begin ma = 41'(ks_q); mb = 29'(vy_q); end
      S_VX, S_VY: begin ma = 41'(tmp_q); mb = $signed({5'd0, dt_q}); end
      S_PX:  begin ma = 41'(vx_q); mb = $signed({5'd0, dt_q}); end
      S_PY:  begin ma = 41'(vy_q); mb = $signed({5'd0, dt_q}); end
      S_DL:  begin ma = $signed({13'd0, rt_root}); mb = $signed({5'd0, dt_q}); end
      default: ;
    endcase
  end

  assign rt_start = (st_q == S_SQ1) || (st_q == S_SQ3);
  assign s_axis_tready = (st_q == S_IDLE) && !ovalid_q;

  logic signed [63:0] pr64;
  logic [P-1:0] lmax;
  logic [P:0] lsum;
  assign pr64 = prod[63:0];
  assign rt_rad = acc_q[55:0] + pr64[55:0];
  assign lmax = {1'b0, {(P-1){1'b1}}};
  assign lsum = {2'b00, len_q} + (P+1)'(pr64[63:24]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ovalid_q <= 1'b0; fin_q <= 1'b0;
      px_q <= '0; py_q <= '0; vx_q <= '0; vy_q <= '0; len_q <= '0;
      acc_q <= '0; tmp_q <= '0; ks_q <= '0;
    end else begin
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      case (st_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          if (!s_axis_tuser) begin
            vx_q <= s_axis_tdata[27:0]; vy_q <= s_axis_tdata[55:28];
            px_q <= '0; py_q <= '0; len_q <= '0; fin_q <= 1'b0;
            st_q <= S_OUT;
          end else if (fin_q || (py_q < floor_q)) begin
            fin_q <= 1'b1; st_q <= S_OUT;
          end else st_q <= S_SQ0;
        end
        S_SQ0, S_SQ2: begin acc_q <= pr64; st_q <= state_e'(st_q + 4'd1); end
        S_SQ1: begin acc_q <= acc_q + pr64; st_q <= S_RT0; end
        S_SQ3: begin acc_q <= acc_q + pr64; st_q <= S_RT1; end
        S_RT0: if (rt_done) st_q <= S_KS;
        S_RT1: if (rt_done) st_q <= S_DL;
        S_KS: begin ks_q <= 36'(pr64 >>> 32); st_q <= S_TX; end
        S_TX: begin tmp_q <= pr64 >>> 16; st_q <= S_VX; end
        S_VX: begin vx_q <= sat28(64'(vx_q) - (pr64 >>> 24)); st_q <= S_TY; end
        S_TY: begin tmp_q <= (pr64 >>> 16) + $signed(64'(grav_q)); st_q <= S_VY; end
        S_VY: begin vy_q <= sat28(64'(vy_q) - (pr64 >>> 24)); st_q <= S_PX; end
        S_PX: begin px_q <= satp(px_q, pr64 >>> 24); st_q <= S_PY; end
        S_PY: begin py_q <= satp(py_q, pr64 >>> 24); st_q <= S_SQ2; end
        S_DL: begin
          len_q <= (lsum > {1'b0, lmax}) ? lmax[P-2:0] : lsum[P-2:0];
          fin_q <= py_q < floor_q;
          st_q <= S_OUT;
        end
        S_OUT: if (!ovalid_q) begin ovalid_q <= 1'b1; st_q <= S_IDLE; end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = OW'({fin_q, len_q, vy_q, vx_q, py_q, px_q});

  `include "ballistic_drag_euler_step_defines.svh"
  `BDE_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, s_axis_tready, st_q == S_IDLE)
  `BDE_ASSERT_NXT(a_launch_clear, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready && !s_axis_tuser, !fin_q && len_q == '0)
  `BDE_ASSERT_IMP(a_no_busy_out, clk_i, rst_ni, ovalid_q, st_q == S_IDLE)
endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bde_pkg::*;

  localparam int PW = PosWidthDef;
  localparam int OW = ((3*PW+56)+7)/8*8;
  localparam longint VMAX = (longint'(1) << 27) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam longint PMAX = (longint'(1) << (PW-1)) - 1;
  localparam longint PMIN = -PMAX - 1;

  typedef struct {
    longint px, py, vx, vy, len;
    bit     fin;
  } traj_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [55:0] s_axis_tdata = '0;   // launch_vx, launch_vy
  logic s_axis_tuser = 1'b0;        // mode
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OW-1:0] m_axis_tdata;      // pos_x, pos_y, vel_x, vel_y, path_length, below_floor
  logic cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [CfgDatWidth-1:0] cfg_data_i = '0;

  ballistic_drag_euler_step dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state and registers
  traj_t  flight;
  longint unsigned dt_q, drag_q, grav_q;
  longint floor_q;
  traj_t  expected_q[$];
  int     n_err, n_res, n_fin, n_launch;
  bit     busy_burst;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned speed(longint a, longint b);
    return int_sqrt(longint'(a*a) + longint'(b*b));
  endfunction

  function automatic longint clampv(longint x);
    return x < VMIN ? VMIN : (x > VMAX ? VMAX : x);
  endfunction

  function automatic longint pos_sum(longint a, longint b);
    if (b > 0 && a > PMAX - b) return PMAX;
    if (b < 0 && a < PMIN - b) return PMIN;
    return a + b;
  endfunction

  task automatic euler_step();
    longint dt, ks, tx, ty, nvx, nvy, dl;
    dt  = longint'(dt_q);
    ks  = longint'((drag_q * speed(flight.vx, flight.vy)) >> 32);
    tx  = (ks * flight.vx) >>> 16;
    ty  = ((ks * flight.vy) >>> 16) + longint'(grav_q);
    nvx = clampv(flight.vx - ((tx * dt) >>> 24));
    nvy = clampv(flight.vy - ((ty * dt) >>> 24));
    flight.vx = nvx;
    flight.vy = nvy;
    flight.px = pos_sum(flight.px, (nvx * dt) >>> 24);
    flight.py = pos_sum(flight.py, (nvy * dt) >>> 24);
    dl = longint'((speed(nvx, nvy) * dt_q) >> 24);
    flight.len = (flight.len > PMAX - dl) ? PMAX : flight.len + dl;
    flight.fin = flight.py < floor_q;
  endtask

  task automatic predict(bit mode, logic [27:0] lvx, logic [27:0] lvy);
    if (!mode) begin
      flight = '{px: 0, py: 0, vx: longint'($signed(lvx)), vy: longint'($signed(lvy)),
                 len: 0, fin: 0};
      n_launch++;
    end else if (flight.fin || flight.py < floor_q) begin
      flight.fin = 1'b1;
    end else begin
      euler_step();
    end
    expected_q = {expected_q, flight};
  endtask

  function automatic int pick_gap();
    int r;
    if (busy_burst) return 0;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_beat(bit mode, logic [27:0] lvx, logic [27:0] lvy);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {lvy, lvx};
    do @(posedge clk_i); while (!s_axis_tready);
    predict(mode, lvx, lvy);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, longint value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[47:0];
    @(posedge clk_i);
    case (idx)
      CfgTimeStep: dt_q    = value & 64'hFF_FFFF;
      CfgDrag:     drag_q  = value & 64'hFFFF_FFFF;
      CfgGravity:  grav_q  = value & 64'hFF_FFFF;
      CfgFloor:    floor_q = longint'($signed(value[47:0]));
      default: ;
    endcase
  endtask

  task automatic set_regs(longint dt, longint dg, longint gr, longint fl);
    drain();
    write_reg(CfgTimeStep, dt);
    write_reg(CfgDrag, dg);
    write_reg(CfgGravity, gr);
    write_reg(CfgFloor, fl);
    cfg_we_i <= 1'b0;
  endtask

  // result side: random stalls, one check per accepted beat
  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(0, 19);
    m_axis_tready <= busy_burst ? 1'b1 : (r < 13 ? 1'b1 : (r < 19 ? 1'b0 : ($urandom_range(0, 7) == 0)));
  end

  always @(posedge clk_i) begin
    traj_t e;
    logic [PW-1:0] apx, apy;
    logic [27:0] avx, avy;
    logic [PW-2:0] alen;
    logic afin;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      apx  = m_axis_tdata[PW-1:0];
      apy  = m_axis_tdata[2*PW-1:PW];
      avx  = m_axis_tdata[2*PW+27:2*PW];
      avy  = m_axis_tdata[2*PW+55:2*PW+28];
      alen = m_axis_tdata[3*PW+54:2*PW+56];
      afin = m_axis_tdata[3*PW+55];
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: %h", $time, m_axis_tdata);
        n_err++;
      end else begin
        e = expected_q.pop_front();
        n_res++;
        if (afin) n_fin++;
        if (apx !== e.px[PW-1:0])
          begin $display("%0t: pos_x exp %h got %h", $time, e.px[PW-1:0], apx); n_err++; end
        if (apy !== e.py[PW-1:0])
          begin $display("%0t: pos_y exp %h got %h", $time, e.py[PW-1:0], apy); n_err++; end
        if (avx !== e.vx[27:0])
          begin $display("%0t: vel_x exp %h got %h", $time, e.vx[27:0], avx); n_err++; end
        if (avy !== e.vy[27:0])
          begin $display("%0t: vel_y exp %h got %h", $time, e.vy[27:0], avy); n_err++; end
        if (alen !== e.len[PW-2:0])
          begin $display("%0t: path_length exp %h got %h", $time, e.len[PW-2:0], alen); n_err++; end
        if (afin !== e.fin)
          begin $display("%0t: below_floor exp %b got %b", $time, e.fin, afin); n_err++; end
      end
    end
  end

  function automatic logic [27:0] rand_vel();
    int sh;
    sh = $urandom_range(0, 12);
    return 28'($signed(28'($urandom())) >>> sh);
  endfunction

  task automatic test_defaults();
    send_beat(1'b1, '0, '0);
    send_beat(1'b0, 28'h0140000, 28'h0320000);
    repeat (5) send_beat(1'b1, 28'hFFFFFFF, 28'hFFFFFFF);
  endtask

  task automatic test_extremes();
    set_regs(24'hFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 0);
    send_beat(1'b0, 28'h7FFFFFF, 28'h8000000);
    repeat (3) send_beat(1'b1, '0, '0);
    send_beat(1'b0, 28'h8000000, 28'h7FFFFFF);
    repeat (3) send_beat(1'b1, '0, '0);
    set_regs(0, 0, 0, -(longint'(1) << 47));
    send_beat(1'b0, 28'h5555555, 28'hAAAAAAA);
    repeat (3) send_beat(1'b1, '0, '0);
  endtask

  task automatic test_floor_cases();
    set_regs(24'h100000, 0, 24'h9CE80, -(longint'(1) << 47));
    send_beat(1'b0, 28'h0010000, 28'hFF00000);
    repeat (3) send_beat(1'b1, '0, '0);
    // floor raised above current height: no step, flag set
    set_regs(24'h100000, 0, 24'h9CE80, 0);
    repeat (3) send_beat(1'b1, 28'h1234567, 28'h7654321);
    send_beat(1'b0, 28'h0010000, 28'h0000000);
    send_beat(1'b1, '0, '0);
    send_beat(1'b1, '0, '0);
  endtask

  task automatic test_random_flights();
    int nsteps;
    int sent;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_regs(24'd1678, 32'd203885, 24'd642689, -478412800);
        6: set_regs(24'hFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 0);
        default: set_regs($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 12),
                          $urandom() >> $urandom_range(0, 20),
                          $urandom_range(0, 24'hFFFFFF),
                          -longint'($urandom_range(0, 3000)) * 65536);
      endcase
      sent = 0;
      while (sent < 150) begin
        busy_burst = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 9) == 0) begin
          send_beat($urandom_range(0, 1), 28'($urandom()), 28'($urandom()));
          sent++;
        end else begin
          send_beat(1'b0, rand_vel(), rand_vel());
          nsteps = $urandom_range(3, 40);
          repeat (nsteps) send_beat(1'b1, 28'($urandom()), 28'($urandom()));
          sent += nsteps + 1;
        end
      end
      busy_burst = 1'b0;
    end
  endtask

  initial begin
    flight = '{default: 0};
    dt_q = TimeStepRst; drag_q = DragRst; grav_q = GravityRst;
    floor_q = longint'(FloorRst);
    n_err = 0; n_res = 0; n_fin = 0; n_launch = 0;
    busy_burst = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_extremes();
    test_floor_cases();
    test_random_flights();
    drain();
    $display("checked %0d result beats: %0d launches, %0d below floor", n_res, n_launch, n_fin);
    if (n_err == 0 && expected_q.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
